### hdl/rpt_pkg.sv
package rpt_pkg;

  localparam int DIST_BITS = 20;
  localparam int FRAC_BITS = 16;
  localparam int COS_DEPTH = 1024;

  localparam int RW        = 19;
  localparam int AW        = 17;
  localparam int TCW       = 8;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 3;

  localparam int HW      = FRAC_BITS + 1;
  localparam int MAG_W   = DIST_BITS;
  localparam int DD_W    = DIST_BITS + 1;
  localparam int CMP_W   = (DD_W > RW + 1) ? DD_W : RW + 1;
  localparam int MULT_W  = TCW + 1;
  localparam int NUM_W   = MAG_W + MULT_W;
  localparam int PH_W    = 32;
  localparam int DIV_W   = NUM_W + PH_W;
  localparam int CIDX_W  = $clog2(COS_DEPTH + 1);
  localparam int POS_W   = PH_W - 2;
  localparam int PROD_W  = POS_W + CIDX_W + 1;
  localparam int PAC_W   = 2 * (HW + 1);
  localparam int PH2_W   = 2 * HW;
  localparam int SUM_W   = 2 * HW + 3;

  localparam logic [HW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RIDGE_WIDTH  = 3'd0,
    REG_EDGE_WIDTH   = 3'd1,
    REG_TEX_ENABLE   = 3'd2,
    REG_TEX_AMP      = 3'd3,
    REG_TEX_CYCLES   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic full;
    logic zero;
  } div_side_t;

  typedef struct packed {
    logic [CIDX_W-1:0] addr;
    logic              neg;
  } cos_addr_t;

  typedef logic [HW-1:0] cos_tab_t [COS_DEPTH+1];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          Q30_ONE     = 64'sd1 << 30;
  localparam longint          ONE_L       = 64'sd1 << FRAC_BITS;
  localparam longint unsigned DEPTH_L     = 64'(COS_DEPTH);
  localparam longint unsigned TAYLOR_DEN [6] = '{132, 90, 56, 30, 12, 2};

  // quarter-wave cosine, integer taylor series in q30 then rounded
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t        tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint          t;
    longint          q;
    for (int k = 0; k <= COS_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * 64'(k)) / DEPTH_L;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 6; i++) begin
        if (t < 0) t = 0;
        p = (x2 * 64'(t)) >> 30;
        t = Q30_ONE - longint'(p / TAYLOR_DEN[i]);
      end
      if (t < 0) t = 0;
      q = (t + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (q > ONE_L) q = ONE_L;
      tab[k] = HW'(q);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  // turn fraction to table entry and sign, nearest entry
  function automatic cos_addr_t cos_addr(input logic [PH_W-1:0] ph);
    cos_addr_t         r;
    logic [PROD_W-1:0] prod;
    logic [CIDX_W-1:0] idx;
    logic [CIDX_W-1:0] rev;
    prod = PROD_W'(ph[POS_W-1:0]) * PROD_W'(COS_DEPTH) + (PROD_W'(1) << (POS_W - 1));
    idx  = prod[POS_W +: CIDX_W];
    rev  = CIDX_W'(COS_DEPTH) - idx;
    case (ph[PH_W-1:PH_W-2])
      2'd0: r = '{addr: idx, neg: 1'b0};
      2'd1: r = '{addr: rev, neg: 1'b1};
      2'd2: r = '{addr: idx, neg: 1'b1};
      default: r = '{addr: rev, neg: 1'b0};
    endcase
    return r;
  endfunction

endpackage

### hdl/rpt_in_if.sv
interface rpt_in_if import rpt_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DIST_BITS-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

### hdl/rpt_out_if.sv
interface rpt_out_if import rpt_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [HW-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

### hdl/rpt_div.sv
module rpt_div import rpt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  div_side_t        side_i,
  input  logic [DIV_W-1:0] num_e_i,
  input  logic [DIV_W-1:0] num_t_i,
  input  logic [RW-1:0]    den_e_i,
  input  logic [RW-1:0]    den_t_i,
  output div_side_t        side_o,
  output logic [PH_W-1:0]  q_e_o,
  output logic [PH_W-1:0]  q_t_o
);

  typedef struct packed {
    logic [DIV_W-1:0] nq;
    logic [RW-1:0]    rem;
  } step_t;

  // one restoring step: numerator bits leave at the top, quotient bits enter at the bottom
  function automatic step_t div_step(input logic [DIV_W-1:0] nq, input logic [RW-1:0] rem,
                                     input logic [RW-1:0] den);
    step_t       r;
    logic [RW:0] t;
    logic [RW:0] diff;
    logic        ge;
    t    = {rem, nq[DIV_W-1]};
    diff = t - {1'b0, den};
    ge   = t >= {1'b0, den};
    r.rem = ge ? diff[RW-1:0] : t[RW-1:0];
    r.nq  = {nq[DIV_W-2:0], ge};
    return r;
  endfunction

  div_side_t        side_r  [DIV_W];
  logic [DIV_W-1:0] nq_e_r  [DIV_W];
  logic [DIV_W-1:0] nq_t_r  [DIV_W];
  logic [RW-1:0]    rem_e_r [DIV_W];
  logic [RW-1:0]    rem_t_r [DIV_W];

  for (genvar s = 0; s < DIV_W; s++) begin : g_step
    div_side_t        side_prev;
    logic [DIV_W-1:0] nq_e_prev;
    logic [DIV_W-1:0] nq_t_prev;
    logic [RW-1:0]    rem_e_prev;
    logic [RW-1:0]    rem_t_prev;
    step_t            st_e_nxt;
    step_t            st_t_nxt;

    if (s == 0) begin : g_first
      assign side_prev  = side_i;
      assign nq_e_prev  = num_e_i;
      assign nq_t_prev  = num_t_i;
      assign rem_e_prev = '0;
      assign rem_t_prev = '0;
    end else begin : g_next
      assign side_prev  = side_r[s-1];
      assign nq_e_prev  = nq_e_r[s-1];
      assign nq_t_prev  = nq_t_r[s-1];
      assign rem_e_prev = rem_e_r[s-1];
      assign rem_t_prev = rem_t_r[s-1];
    end

    assign st_e_nxt = div_step(nq_e_prev, rem_e_prev, den_e_i);
    assign st_t_nxt = div_step(nq_t_prev, rem_t_prev, den_t_i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s] <= '0;
      end else if (en) begin
        side_r[s] <= side_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_e_r[s]  <= st_e_nxt.nq;
        nq_t_r[s]  <= st_t_nxt.nq;
        rem_e_r[s] <= st_e_nxt.rem;
        rem_t_r[s] <= st_t_nxt.rem;
      end
    end
  end

  assign side_o = side_r[DIV_W-1];
  assign q_e_o  = nq_e_r[DIV_W-1][PH_W-1:0];
  assign q_t_o  = nq_t_r[DIV_W-1][PH_W-1:0];

endmodule

### hdl/ridge_profile_with_texture.sv
// Ridge height profile with optional cosine texture. Each word on in_chan carries a signed
// distance from the ridge centre; out_chan returns one height word (q1.16, 65536 = 1.0) per
// input word, in order. The block is a fixed pipeline that takes one word every cycle unless
// out_chan stalls. Its stages are the input register, region compare, a 61-stage restoring
// divider that yields one quotient bit per stage for both the edge phase and the texture
// phase, cosine index, table read, edge height, multiply, sum and output register.
// A stall on out_chan freezes the whole pipeline; ready is high whenever the output register
// is empty or being taken. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must do so only while no word is in flight, as the block does not enforce this.
module ridge_profile_with_texture import rpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rpt_in_if.sink               in_chan,
  rpt_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration
  logic [RW-1:0]  ridge_width_r;
  logic [RW-1:0]  edge_width_r;
  logic           tex_enable_r;
  logic [AW-1:0]  tex_amp_r;
  logic [TCW-1:0] tex_cycles_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ridge_width_r <= RW'(2048);
      edge_width_r  <= RW'(512);
      tex_enable_r  <= 1'b0;
      tex_amp_r     <= '0;
      tex_cycles_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RIDGE_WIDTH: ridge_width_r <= cfg_data[RW-1:0];
        REG_EDGE_WIDTH:  edge_width_r  <= cfg_data[RW-1:0];
        REG_TEX_ENABLE:  tex_enable_r  <= cfg_data[0];
        REG_TEX_AMP:     tex_amp_r     <= cfg_data[AW-1:0];
        REG_TEX_CYCLES:  tex_cycles_r  <= cfg_data[TCW-1:0];
        default: ;
      endcase
    end
  end

  // values derived from configuration
  logic [RW:0]       e2w_nxt;
  logic [RW-1:0]     e2_nxt;
  logic [RW-1:0]     e2_r;
  logic [RW-1:0]     inner_r;
  logic [MULT_W-1:0] mult_r;
  logic [HW-1:0]     a_sat_r;
  logic              tex_on_r;
  logic              w_zero_r;
  logic              e2_zero_r;

  assign e2w_nxt = {edge_width_r, 1'b0};
  assign e2_nxt  = (e2w_nxt > {1'b0, ridge_width_r}) ? ridge_width_r : e2w_nxt[RW-1:0];

  always_ff @(posedge clk) begin
    e2_r      <= e2_nxt;
    inner_r   <= ridge_width_r - e2_nxt;
    e2_zero_r <= (e2_nxt == '0);
    mult_r    <= {tex_cycles_r, 1'b1};
    a_sat_r   <= (tex_amp_r > AW'(ONE)) ? ONE : HW'(tex_amp_r);
    tex_on_r  <= tex_enable_r && (tex_amp_r != '0);
    w_zero_r  <= (ridge_width_r == '0);
  end

  logic en;
  logic out_valid_r;
  logic [HW-1:0] height_r;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // stage 0: magnitude of the distance
  logic [MAG_W-1:0] mag_nxt;
  logic             v0_r;
  logic [MAG_W-1:0] mag0_r;

  assign mag_nxt = in_chan.distance[DIST_BITS-1] ? (~in_chan.distance + MAG_W'(1))
                                                 : in_chan.distance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0_r <= mag_nxt;
    end
  end

  // stage 1: region compare, edge offset and texture numerator
  logic [CMP_W-1:0] dd_nxt;
  logic [CMP_W-1:0] w_c;
  logic [CMP_W-1:0] inner_c;
  logic [CMP_W-1:0] x_full;
  logic             lt_inner;
  logic             gt_w;
  div_side_t        side1_r;
  logic [RW-1:0]    x1_r;
  logic [NUM_W-1:0] num1_r;

  assign dd_nxt   = CMP_W'({mag0_r, 1'b0});
  assign w_c      = CMP_W'(ridge_width_r);
  assign inner_c  = CMP_W'(inner_r);
  assign lt_inner = dd_nxt < inner_c;
  assign gt_w     = dd_nxt > w_c;
  assign x_full   = dd_nxt - inner_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
    end else if (en) begin
      side1_r.valid <= v0_r;
      side1_r.full  <= lt_inner || (!gt_w && e2_zero_r);
      side1_r.zero  <= !lt_inner && gt_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x_full[RW-1:0];
      num1_r <= NUM_W'(mag0_r) * NUM_W'(mult_r);
    end
  end

  // phase division
  div_side_t       side_d;
  logic [PH_W-1:0] q_e;
  logic [PH_W-1:0] q_t;

  rpt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .side_i  (side1_r),
    .num_e_i (DIV_W'(x1_r) << (PH_W - 1)),
    .num_t_i ({num1_r, {PH_W{1'b0}}}),
    .den_e_i (e2_r),
    .den_t_i (ridge_width_r),
    .side_o  (side_d),
    .q_e_o   (q_e),
    .q_t_o   (q_t)
  );

  // stage 2: table address and sign
  div_side_t side2_r;
  cos_addr_t ca_e2_r;
  cos_addr_t ca_t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r <= '0;
    end else if (en) begin
      side2_r <= side_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_e2_r <= cos_addr(q_e);
      ca_t2_r <= cos_addr(w_zero_r ? '0 : q_t);
    end
  end

  // stage 3: table read
  div_side_t     side3_r;
  logic [HW-1:0] cm_e3_r;
  logic [HW-1:0] cm_t3_r;
  logic          neg_e3_r;
  logic          neg_t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r <= '0;
    end else if (en) begin
      side3_r <= side2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_e3_r  <= COS_TAB[ca_e2_r.addr];
      cm_t3_r  <= COS_TAB[ca_t2_r.addr];
      neg_e3_r <= ca_e2_r.neg;
      neg_t3_r <= ca_t2_r.neg;
    end
  end

  // stage 4: edge height and signed texture cosine
  logic signed [HW:0] ce_nxt;
  logic signed [HW:0] ct_nxt;
  logic [HW+1:0]      hs_nxt;
  logic [HW-1:0]      h_nxt;
  logic               v4_r;
  logic [HW-1:0]      h4_r;
  logic signed [HW:0] ct4_r;

  assign ce_nxt = neg_e3_r ? -$signed({1'b0, cm_e3_r}) : $signed({1'b0, cm_e3_r});
  assign ct_nxt = neg_t3_r ? -$signed({1'b0, cm_t3_r}) : $signed({1'b0, cm_t3_r});
  assign hs_nxt = (HW+2)'(ONE) + (HW+2)'(ce_nxt) + (HW+2)'(1);

  always_comb begin
    if (side3_r.full) begin
      h_nxt = ONE;
    end else if (side3_r.zero) begin
      h_nxt = '0;
    end else begin
      h_nxt = hs_nxt[HW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= side3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h4_r  <= h_nxt;
      ct4_r <= ct_nxt;
    end
  end

  // stage 5: texture products
  logic signed [PAC_W-1:0] pac_nxt;
  logic                    v5_r;
  logic [HW-1:0]           h5_r;
  logic signed [PAC_W-1:0] pac5_r;
  logic [PH2_W-1:0]        ph5_r;

  assign pac_nxt = PAC_W'($signed({1'b0, a_sat_r})) * PAC_W'(ct4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h5_r   <= h4_r;
      pac5_r <= pac_nxt;
      ph5_r  <= PH2_W'(ONE - a_sat_r) * PH2_W'(h4_r);
    end
  end

  // output: mix, round, clamp
  logic signed [SUM_W-1:0] total_nxt;
  logic [SUM_W-1:0]        tpos_nxt;
  logic [SUM_W-1:0]        rs_nxt;
  logic [HW-1:0]           res_nxt;

  assign total_nxt = SUM_W'(pac5_r) + $signed(SUM_W'({ph5_r, 1'b0}))
                   + $signed(SUM_W'(a_sat_r) << FRAC_BITS);
  assign tpos_nxt  = total_nxt[SUM_W-1] ? '0 : SUM_W'(total_nxt);
  assign rs_nxt    = (tpos_nxt + SUM_W'(ONE)) >> HW;
  assign res_nxt   = (rs_nxt > SUM_W'(ONE)) ? ONE : rs_nxt[HW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      height_r <= tex_on_r ? res_nxt : h5_r;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.height = height_r;

endmodule

### tb/sv/ridge_profile_with_texture_checker.sv
`timescale 1ns / 1ps

module ridge_profile_with_texture_checker import rpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rpt_in_if                    in_mon,
  rpt_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint          UNIT_Q30         = 64'sd1 << 30;
  localparam longint          FULL             = 64'sd1 << FRAC_BITS;
  localparam longint unsigned SERIES_DIV [6]   = '{132, 90, 56, 30, 12, 2};
  localparam int              RIDGE_AT_RESET   = 2048;
  localparam int              RIM_AT_RESET     = 512;

  longint         quarter_cos [COS_DEPTH+1];
  logic [RW-1:0]  ridge_w;
  logic [RW-1:0]  rim_w;
  logic           tex_on;
  logic [AW-1:0]  tex_amp;
  logic [TCW-1:0] tex_n;
  logic [HW-1:0]  heights_due [$];

  // quarter-wave cosine from a q30 taylor series, rounded to the height format
  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint          t;
    mismatches  = 0;
    outstanding = 0;
    for (int k = 0; k <= COS_DEPTH; k++) begin
      x  = QUARTER_TURN_Q30 * 64'(k) / 64'(COS_DEPTH);
      x2 = (x * x) >> 30;
      t  = UNIT_Q30;
      for (int i = 0; i < 6; i++) begin
        if (t < 0) t = 0;
        p = (x2 * 64'(t)) >> 30;
        t = UNIT_Q30 - longint'(p / SERIES_DIV[i]);
      end
      if (t < 0) t = 0;
      quarter_cos[k] = (t + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (quarter_cos[k] > FULL) quarter_cos[k] = FULL;
    end
  end

  function automatic longint cos_at_turn(logic [31:0] ph);
    longint unsigned slot;
    slot = ((64'(ph[29:0]) * 64'(COS_DEPTH)) + (64'd1 << 29)) >> 30;
    case (ph[31:30])
      2'd0: return quarter_cos[slot];
      2'd1: return -quarter_cos[COS_DEPTH - slot];
      2'd2: return -quarter_cos[slot];
      default: return quarter_cos[COS_DEPTH - slot];
    endcase
  endfunction

  // distances compared in doubled units so the radius stays exact
  function automatic logic [HW-1:0] expected_height(logic signed [DIST_BITS-1:0] d_in);
    longint          sd;
    longint unsigned mag;
    longint unsigned dd;
    longint unsigned w;
    longint unsigned e2;
    longint unsigned inner;
    longint unsigned num;
    longint          h;
    longint          c;
    longint          a;
    longint          total;
    longint          res;
    logic [31:0]     ph;
    sd    = d_in;
    mag   = (sd < 0) ? -sd : sd;
    dd    = mag * 2;
    w     = 64'(ridge_w);
    e2    = 64'(rim_w) * 2;
    if (e2 > w) e2 = w;
    inner = w - e2;
    if (dd < inner) begin
      h = FULL;
    end else if (dd > w) begin
      h = 0;
    end else if (e2 == 0) begin
      h = FULL;
    end else begin
      ph = 32'(((dd - inner) << 31) / e2);
      c  = cos_at_turn(ph);
      h  = (FULL + c + 1) >>> 1;
    end
    res = h;
    if (tex_on && tex_amp != 0) begin
      a = 64'(tex_amp);
      if (a > FULL) a = FULL;
      ph = 32'd0;
      if (w != 0) begin
        num = mag * (64'(tex_n) * 2 + 1);
        ph  = 32'(((num % w) << 32) / w);
      end
      c     = cos_at_turn(ph);
      total = a * c + 2 * (FULL - a) * h + a * FULL;
      if (total < 0) total = 0;
      res = (total + FULL) >>> (FRAC_BITS + 1);
      if (res > FULL) res = FULL;
    end
    return HW'(res);
  endfunction

  always @(posedge clk) begin
    logic [HW-1:0] due;
    if (!rst_n) begin
      ridge_w = RW'(RIDGE_AT_RESET);
      rim_w   = RW'(RIM_AT_RESET);
      tex_on  = 1'b0;
      tex_amp = '0;
      tex_n   = '0;
      heights_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RIDGE_WIDTH: ridge_w = cfg_data[RW-1:0];
          REG_EDGE_WIDTH:  rim_w   = cfg_data[RW-1:0];
          REG_TEX_ENABLE:  tex_on  = cfg_data[0];
          REG_TEX_AMP:     tex_amp = cfg_data[AW-1:0];
          REG_TEX_CYCLES:  tex_n   = cfg_data[TCW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        heights_due.push_back(expected_height(in_mon.distance));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (heights_due.size() == 0) begin
          $display("%0t: height expected none actual %0d", $time, out_mon.height);
          mismatches++;
        end else begin
          due = heights_due.pop_front();
          if (out_mon.height !== due) begin
            $display("%0t: height expected %0d actual %0d", $time, due, out_mon.height);
            mismatches++;
          end
        end
      end
    end
    outstanding = heights_due.size();
  end

endmodule

### tb/sv/ridge_profile_with_texture_tb.sv
`timescale 1ns / 1ps

module ridge_profile_with_texture_tb;
  import rpt_pkg::*;

  localparam longint DIST_MAX = (64'sd1 <<< (DIST_BITS - 1)) - 1;
  localparam longint DIST_MIN = -(64'sd1 <<< (DIST_BITS - 1));

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;
  longint               cur_w;
  longint               cur_e;
  bit                   steady;

  rpt_in_if  in_if ();
  rpt_out_if out_if ();

  ridge_profile_with_texture dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ridge_profile_with_texture_checker height_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("[ridge_profile_with_texture] ERROR");
    $finish;
  end

  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint rim_inner();
    longint e2;
    e2 = (2 * cur_e > cur_w) ? cur_w : 2 * cur_e;
    return (cur_w - e2) / 2;
  endfunction

  // mostly near the ridge, some over the whole range, some on the region borders
  function automatic longint pick_distance();
    int unsigned roll;
    longint      v;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      v = longint'($urandom_range(0, 32'hFFFFF)) + DIST_MIN;
    end else begin
      if (roll < 80) v = $urandom_range(0, 32'(cur_w / 2 + 4));
      else if (roll < 90) v = cur_w / 2 + $urandom_range(0, 4) - 2;
      else v = rim_inner() + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) v = -v;
    end
    return v;
  endfunction

  task automatic send_distance(input longint v);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.distance <= v[DIST_BITS-1:0];
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic drain_heights();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_profile(input longint w, input longint e, input bit en,
                             input longint amp, input longint n);
    write_reg(REG_RIDGE_WIDTH, CFG_W'(w));
    write_reg(REG_EDGE_WIDTH, CFG_W'(e));
    write_reg(REG_TEX_ENABLE, CFG_W'(en));
    write_reg(REG_TEX_AMP, CFG_W'(amp));
    write_reg(REG_TEX_CYCLES, CFG_W'(n));
    cfg_we <= 1'b0;
    cur_w = w;
    cur_e = e;
  endtask

  task automatic run_phase(input int count);
    longint r;
    longint inner;
    r      = cur_w / 2;
    inner  = rim_inner();
    steady = ($urandom_range(0, 3) == 0);
    send_distance(0);
    send_distance(1);
    send_distance(-1);
    send_distance(inner - 1);
    send_distance(inner);
    send_distance(inner + 1);
    send_distance(-inner);
    send_distance(r - 1);
    send_distance(r);
    send_distance(r + 1);
    send_distance(-r);
    send_distance(DIST_MAX);
    send_distance(DIST_MIN);
    repeat (count) send_distance(pick_distance());
    in_if.valid <= 1'b0;
    drain_heights();
  endtask

  initial begin
    int unsigned run_len;
    int unsigned stall;
    int unsigned roll;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      run_len = (roll < 20) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      out_if.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      roll = $urandom_range(0, 99);
      if (roll < 60) stall = $urandom_range(1, 3);
      else if (roll < 90) stall = $urandom_range(4, 10);
      else stall = $urandom_range(20, 40);
      out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
  end

  initial begin
    longint      w;
    longint      e;
    longint      amp;
    bit          en;
    int unsigned roll;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_RIDGE_WIDTH;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.distance <= '0;
    cur_w  = 2048;
    cur_e  = 512;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_phase(30);
    // zero edge, so the rim itself is still full height
    set_profile(2048, 0, 1'b0, 0, 0);
    run_phase(20);
    set_profile(2048, 512, 1'b1, 65536, 0);
    run_phase(30);
    // zero ridge width
    set_profile(0, 300, 1'b1, 30000, 7);
    run_phase(20);
    // widest ridge, edge clamped to radius, amplitude above one
    set_profile(524287, 524287, 1'b1, 131071, 255);
    run_phase(40);
    set_profile(1, 0, 1'b1, 1, 0);
    run_phase(20);

    // upper register bits and unknown indexes must be ignored
    set_profile(1500, 200, 1'b0, 0, 0);
    @(posedge clk);
    write_reg(REG_TEX_ENABLE, {18'h3FFFF, 1'b1});
    write_reg(REG_TEX_AMP, {2'b11, 17'd20000});
    write_reg(REG_TEX_CYCLES, {11'h7FF, 8'd3});
    for (int k = 1; k <= 3; k++) begin
      write_reg(CFG_IDX_W'(REG_TEX_CYCLES) + CFG_IDX_W'(k), CFG_W'($urandom));
    end
    cfg_we <= 1'b0;
    run_phase(30);

    for (int k = 0; k < 8; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) w = $urandom_range(1, 4096);
      else if (roll < 85) w = $urandom_range(4097, 524287);
      else w = $urandom_range(1, 8);
      e  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 32'(w));
      en = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 15) amp = 0;
      else if (roll < 30) amp = 65536;
      else amp = $urandom_range(1, 131071);
      set_profile(w, e, en, amp, $urandom_range(0, 255));
      run_phase(25);
    end

    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ridge_profile_with_texture] OK");
    end else begin
      $display("[ridge_profile_with_texture] ERROR");
    end
    $finish;
  end

endmodule
